[rtl/core/windowed_multi_queue_trace_buffer_core_defines.svh]
// Assertion macros for the trace buffer core.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef WINDOWED_MULTI_QUEUE_TRACE_BUFFER_CORE_DEFINES_SVH
`define WINDOWED_MULTI_QUEUE_TRACE_BUFFER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define WMQTB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wmqtb check failed");
// Next-cycle implication, disabled in reset.
`define WMQTB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wmqtb check failed");
`else
`define WMQTB_ASSERT_IMPL(label, clk, rst, ante, cons)
`define WMQTB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[rtl/core/wmqtb_pkg.sv]
// Shared types, constants and helpers of the trace buffer core.
// No dependencies; the sequencer, datapath and top level import this package.
`default_nettype none
package wmqtb_pkg;

   localparam int NUM_TOPICS        = 4;
   localparam int ENTRIES_PER_TOPIC = 8;
   localparam int STORE_DEPTH       = NUM_TOPICS * ENTRIES_PER_TOPIC;
   localparam int TID_W             = $clog2(NUM_TOPICS);
   localparam int IDX_W             = $clog2(ENTRIES_PER_TOPIC);
   localparam int CNT_W             = $clog2(ENTRIES_PER_TOPIC + 1);
   localparam int ADDR_W            = $clog2(STORE_DEPTH);
   localparam int NCNT_W            = $clog2(STORE_DEPTH + 1);

   localparam int TOPIC_W    = 2;
   localparam int STAMP_W    = 63;
   localparam int LEN_W      = 24;
   localparam int HANDLE_W   = 32;
   localparam int TOTAL_W    = 30;
   localparam int ECOUNT_W   = 6;
   localparam int WIN_W      = 40;
   localparam int DIV_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 40;
   localparam int WIN_REGS   = 4;

   localparam logic OP_MESSAGE  = 1'b0;
   localparam logic OP_SNAPSHOT = 1'b1;

   localparam logic [CSR_DATA_W-1:0] DEFAULT_WINDOW_RESET = 40'd10000000000;

   typedef enum logic [2:0] {
      KIND_ACCEPTED       = 3'd0,
      KIND_SKIPPED        = 3'd1,
      KIND_WINDOW_EVICT   = 3'd2,
      KIND_BUDGET_EVICT   = 3'd3,
      KIND_CAPACITY_EVICT = 3'd4,
      KIND_SNAP_ENTRY     = 3'd5,
      KIND_SNAP_EMPTY     = 3'd6
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TOPIC_WINDOW_0  = 3'd0,
      CSR_TOPIC_WINDOW_1  = 3'd1,
      CSR_TOPIC_WINDOW_2  = 3'd2,
      CSR_TOPIC_WINDOW_3  = 3'd3,
      CSR_DEFAULT_WINDOW  = 3'd4,
      CSR_RATE_DIVISORS   = 3'd5,
      CSR_MAX_TOTAL_BYTES = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SKIP,
      ST_CAP_RD,
      ST_CAP_EMIT,
      ST_APPEND,
      ST_WIN_RD,
      ST_WIN_CHK,
      ST_BUD_CHK,
      ST_BUD_SCAN,
      ST_BUD_DRAIN,
      ST_BUD_EMIT,
      ST_DONE,
      ST_SNAP_INIT,
      ST_SNAP_EMPTY,
      ST_SNAP_SCAN,
      ST_SNAP_DRAIN,
      ST_SNAP_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [STAMP_W-1:0]  wall;
      logic [LEN_W-1:0]    length;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic [STAMP_W-1:0] stamp;
      logic [TID_W-1:0]   topic;
      logic [IDX_W-1:0]   idx;
   } key_type;

   typedef struct packed {
      logic     take;
      logic     decimate;
      logic     rd_head;
      logic     append;
      logic     scan_start;
      logic     scan_step;
      logic     snap_init;
      logic     emit;
      logic     pop;
      logic     last;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic req_valid;
      logic is_snapshot;
      logic topic_ok;
      logic keep;
      logic queue_full;
      logic win_evict;
      logic over_budget;
      logic bud_last;
      logic scan_last;
      logic snap_empty;
      logic snap_last;
      logic out_free;
   } status_type;

   // Store address of entry off (0 = oldest) of topic t.
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [TID_W-1:0] t,
                                                  input logic [IDX_W-1:0] head,
                                                  input logic [IDX_W-1:0] off);
      logic [IDX_W:0]  idx;
      logic [ADDR_W:0] base;
      idx = {1'b0, head} + {1'b0, off};
      if (idx >= (IDX_W+1)'(ENTRIES_PER_TOPIC)) begin
         idx = idx - (IDX_W+1)'(ENTRIES_PER_TOPIC);
      end
      base = (ADDR_W+1)'(t) * (ADDR_W+1)'(ENTRIES_PER_TOPIC);
      return ADDR_W'(base + (ADDR_W+1)'(idx));
   endfunction

endpackage
`default_nettype wire

[rtl/core/wmqtb_req_if.sv]
// Input channel of the trace buffer: valid/ready plus one request word.
// Depends on nothing.
`default_nettype none
interface wmqtb_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [1:0]  topic;
   logic [62:0] stamp_ns;
   logic [62:0] wall_stamp_ns;
   logic [23:0] payload_length;
   logic [31:0] payload_handle;

   modport source (output valid, op, topic, stamp_ns, wall_stamp_ns, payload_length,
                   payload_handle, input ready);
   modport sink (input valid, op, topic, stamp_ns, wall_stamp_ns, payload_length,
                 payload_handle, output ready);
endinterface
`default_nettype wire

[rtl/core/wmqtb_rsp_if.sv]
// Result channel of the trace buffer: valid/ready plus one result word.
// Depends on nothing.
`default_nettype none
interface wmqtb_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [1:0]  entry_topic;
   logic [62:0] entry_stamp_ns;
   logic [62:0] entry_wall_ns;
   logic [23:0] entry_length;
   logic [31:0] entry_handle;
   logic [29:0] total_bytes;
   logic [5:0]  entry_count;
   logic        last;

   modport source (output valid, kind, entry_topic, entry_stamp_ns, entry_wall_ns,
                   entry_length, entry_handle, total_bytes, entry_count, last,
                   input ready);
   modport sink (input valid, kind, entry_topic, entry_stamp_ns, entry_wall_ns,
                 entry_length, entry_handle, total_bytes, entry_count, last,
                 output ready);
endinterface
`default_nettype wire

[rtl/core/wmqtb_csr_if.sv]
// Register write channel of the trace buffer: valid/ready, index and data.
// Depends on nothing.
`default_nettype none
interface wmqtb_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [39:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

[rtl/core/wmqtb_ctrl.sv]
// Sequencer of the trace buffer: one state machine driving the datapath.
// Depends on wmqtb_pkg.
`default_nettype none
module wmqtb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  wmqtb_pkg::status_type  status,
   output wmqtb_pkg::cmd_type     cmd
);
   import wmqtb_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (status.req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.is_snapshot) state_in = ST_SNAP_INIT;
            else if (!status.topic_ok || !status.keep) state_in = ST_SKIP;
            else if (status.queue_full) state_in = ST_CAP_RD;
            else state_in = ST_APPEND;
         end
         ST_SKIP: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_CAP_RD:   state_in = ST_CAP_EMIT;
         ST_CAP_EMIT: begin
            if (status.out_free) state_in = ST_APPEND;
         end
         ST_APPEND:   state_in = ST_WIN_RD;
         ST_WIN_RD:   state_in = ST_WIN_CHK;
         ST_WIN_CHK: begin
            if (!status.win_evict) state_in = ST_BUD_CHK;
            else if (status.out_free) state_in = ST_WIN_RD;
         end
         ST_BUD_CHK: begin
            state_in = status.over_budget ? ST_BUD_SCAN : ST_DONE;
         end
         ST_BUD_SCAN: begin
            if (status.scan_last) state_in = ST_BUD_DRAIN;
         end
         ST_BUD_DRAIN: state_in = ST_BUD_EMIT;
         ST_BUD_EMIT: begin
            if (status.out_free) state_in = status.bud_last ? ST_IDLE : ST_BUD_CHK;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_SNAP_INIT: begin
            state_in = status.snap_empty ? ST_SNAP_EMPTY : ST_SNAP_SCAN;
         end
         ST_SNAP_EMPTY: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         ST_SNAP_SCAN: begin
            if (status.scan_last) state_in = ST_SNAP_DRAIN;
         end
         ST_SNAP_DRAIN: state_in = ST_SNAP_EMIT;
         ST_SNAP_EMIT: begin
            if (status.out_free) state_in = status.snap_last ? ST_IDLE : ST_SNAP_SCAN;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.kind = KIND_ACCEPTED;
      case (state_ff)
         ST_IDLE:   cmd.take = 1'b1;
         ST_DECIDE: cmd.decimate = 1'b1;
         ST_SKIP: begin
            cmd.emit = status.out_free;
            cmd.kind = KIND_SKIPPED;
            cmd.last = 1'b1;
         end
         ST_CAP_RD: cmd.rd_head = 1'b1;
         ST_CAP_EMIT: begin
            cmd.emit = status.out_free;
            cmd.pop  = status.out_free;
            cmd.kind = KIND_CAPACITY_EVICT;
         end
         ST_APPEND: cmd.append = 1'b1;
         ST_WIN_RD: cmd.rd_head = 1'b1;
         ST_WIN_CHK: begin
            cmd.emit = status.win_evict && status.out_free;
            cmd.pop  = status.win_evict && status.out_free;
            cmd.kind = KIND_WINDOW_EVICT;
         end
         ST_BUD_CHK:   cmd.scan_start = status.over_budget;
         ST_BUD_SCAN:  cmd.scan_step = 1'b1;
         ST_BUD_DRAIN: cmd.kind = KIND_BUDGET_EVICT;
         ST_BUD_EMIT: begin
            cmd.emit = status.out_free;
            cmd.pop  = status.out_free;
            cmd.kind = KIND_BUDGET_EVICT;
            cmd.last = status.bud_last;
         end
         ST_DONE: begin
            cmd.emit = status.out_free;
            cmd.kind = KIND_ACCEPTED;
            cmd.last = 1'b1;
         end
         ST_SNAP_INIT: begin
            cmd.snap_init  = 1'b1;
            cmd.scan_start = !status.snap_empty;
         end
         ST_SNAP_EMPTY: begin
            cmd.emit = status.out_free;
            cmd.kind = KIND_SNAP_EMPTY;
            cmd.last = 1'b1;
         end
         ST_SNAP_SCAN:  cmd.scan_step = 1'b1;
         ST_SNAP_DRAIN: cmd.kind = KIND_SNAP_ENTRY;
         ST_SNAP_EMIT: begin
            cmd.emit       = status.out_free;
            cmd.kind       = KIND_SNAP_ENTRY;
            cmd.last       = status.snap_last;
            cmd.scan_start = status.out_free && !status.snap_last;
         end
         default: cmd.kind = KIND_ACCEPTED;
      endcase
   end

endmodule
`default_nettype wire

[rtl/core/wmqtb_datapath.sv]
// Datapath of the trace buffer: registers, queue pointers, entry store,
// scan unit and result register. Depends on wmqtb_pkg and the channel interfaces.
`default_nettype none
module wmqtb_datapath (
   input  logic                  clock,
   input  logic                  reset,
   wmqtb_req_if.sink             req_chan,
   wmqtb_rsp_if.source           rsp_chan,
   wmqtb_csr_if.sink             csr_chan,
   input  wmqtb_pkg::cmd_type    cmd,
   output wmqtb_pkg::status_type status
);
   import wmqtb_pkg::*;

   // configuration
   logic [WIN_W-1:0]      topic_window_ff [WIN_REGS];
   logic [WIN_W-1:0]      default_window_ff;
   logic [DIV_W-1:0]      rate_div_ff;
   logic [CSR_DATA_W-1:0] max_bytes_ff;

   // latched request word
   logic                  in_op_ff;
   logic [TOPIC_W-1:0]    in_topic_ff;
   logic [STAMP_W-1:0]    in_stamp_ff;
   logic [STAMP_W-1:0]    in_wall_ff;
   logic [LEN_W-1:0]      in_len_ff;
   logic [HANDLE_W-1:0]   in_handle_ff;

   // queue state
   logic [IDX_W-1:0]      head_ff  [NUM_TOPICS];
   logic [IDX_W-1:0]      head_in  [NUM_TOPICS];
   logic [CNT_W-1:0]      count_ff [NUM_TOPICS];
   logic [CNT_W-1:0]      count_in [NUM_TOPICS];
   logic [7:0]            arrival_ff [NUM_TOPICS];
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [NCNT_W-1:0]     ecount_ff, ecount_in;

   // entry store
   entry_type             store_ff [STORE_DEPTH];
   entry_type             rd_data_ff;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr;

   // scan unit
   logic [TID_W-1:0]      scan_t_ff;
   logic [IDX_W-1:0]      scan_i_ff;
   logic                  scan_valid;
   logic                  pend_valid_ff;
   logic [TID_W-1:0]      pend_t_ff;
   logic [IDX_W-1:0]      pend_i_ff;
   logic                  best_valid_ff;
   key_type               best_key_ff;
   entry_type             best_data_ff;
   key_type               cand_key;
   logic                  cand_take;
   logic                  snap_mode_ff;
   logic                  first_ff;
   key_type               last_key_ff;
   logic [NCNT_W-1:0]     snap_cnt_ff;

   // result register
   logic                  rsp_valid_ff;
   kind_type              rsp_kind_ff;
   logic [TOPIC_W-1:0]    rsp_topic_ff;
   entry_type             rsp_entry_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;
   logic [ECOUNT_W-1:0]   rsp_count_ff;
   logic                  rsp_last_ff;

   logic [TID_W-1:0]      in_t;
   logic [7:0]            div;
   logic [7:0]            arrival_step;
   logic [WIN_W-1:0]      win;
   logic [TID_W-1:0]      pop_t;
   logic [LEN_W-1:0]      pop_len;
   logic [TOTAL_W-1:0]    bud_total;
   logic [CNT_W-1:0]      bud_count;
   logic                  accept;
   entry_type             emit_entry;
   logic [TOPIC_W-1:0]    emit_topic;

   assign in_t   = in_topic_ff[TID_W-1:0];
   assign accept = cmd.take && req_chan.valid;

   assign req_chan.ready = cmd.take;
   assign csr_chan.ready = 1'b1;

   // configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < WIN_REGS; t++) topic_window_ff[t] <= '0;
         default_window_ff <= DEFAULT_WINDOW_RESET;
         rate_div_ff       <= '0;
         max_bytes_ff      <= '0;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_TOPIC_WINDOW_0:  topic_window_ff[0] <= csr_chan.wdata;
            CSR_TOPIC_WINDOW_1:  topic_window_ff[1] <= csr_chan.wdata;
            CSR_TOPIC_WINDOW_2:  topic_window_ff[2] <= csr_chan.wdata;
            CSR_TOPIC_WINDOW_3:  topic_window_ff[3] <= csr_chan.wdata;
            CSR_DEFAULT_WINDOW:  default_window_ff  <= csr_chan.wdata;
            CSR_RATE_DIVISORS:   rate_div_ff        <= csr_chan.wdata[DIV_W-1:0];
            CSR_MAX_TOTAL_BYTES: max_bytes_ff       <= csr_chan.wdata;
            default:             max_bytes_ff       <= max_bytes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff     <= req_chan.op;
         in_topic_ff  <= req_chan.topic;
         in_stamp_ff  <= req_chan.stamp_ns;
         in_wall_ff   <= req_chan.wall_stamp_ns;
         in_len_ff    <= req_chan.payload_length;
         in_handle_ff <= req_chan.payload_handle;
      end
   end

   // decimation
   assign div = rate_div_ff[8*in_t +: 8];

   always_comb begin
      arrival_step = arrival_ff[in_t] + 8'd1;
      if (arrival_step >= div) arrival_step = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TOPICS; t++) arrival_ff[t] <= '0;
      end else if (cmd.decimate && in_op_ff == OP_MESSAGE && status.topic_ok &&
                   div > 8'd1) begin
         arrival_ff[in_t] <= arrival_step;
      end
   end

   assign win = (topic_window_ff[in_t] == '0) ? default_window_ff : topic_window_ff[in_t];

   // pop target: budget evicts take the scan winner, the rest the arriving topic
   assign pop_t   = (cmd.kind == KIND_BUDGET_EVICT) ? best_key_ff.topic : in_t;
   assign pop_len = (cmd.kind == KIND_BUDGET_EVICT) ? best_data_ff.length
                                                    : rd_data_ff.length;

   always_comb begin
      for (int t = 0; t < NUM_TOPICS; t++) begin
         head_in[t]  = head_ff[t];
         count_in[t] = count_ff[t];
         if (cmd.pop && pop_t == TID_W'(t)) begin
            head_in[t]  = (head_ff[t] == IDX_W'(ENTRIES_PER_TOPIC - 1)) ? '0
                                                                      : head_ff[t] + 1'b1;
            count_in[t] = count_ff[t] - 1'b1;
         end else if (cmd.append && in_t == TID_W'(t)) begin
            count_in[t] = count_ff[t] + 1'b1;
         end
      end
      total_in  = total_ff;
      ecount_in = ecount_ff;
      if (cmd.pop) begin
         total_in  = total_ff - TOTAL_W'(pop_len);
         ecount_in = ecount_ff - 1'b1;
      end else if (cmd.append) begin
         total_in  = total_ff + TOTAL_W'(in_len_ff);
         ecount_in = ecount_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < NUM_TOPICS; t++) begin
            head_ff[t]  <= '0;
            count_ff[t] <= '0;
         end
         total_ff  <= '0;
         ecount_ff <= '0;
      end else begin
         for (int t = 0; t < NUM_TOPICS; t++) begin
            head_ff[t]  <= head_in[t];
            count_ff[t] <= count_in[t];
         end
         total_ff  <= total_in;
         ecount_ff <= ecount_in;
      end
   end

   // entry store: one write, one registered read
   assign scan_valid = (CNT_W'(scan_i_ff) < count_ff[scan_t_ff]) &&
                       (snap_mode_ff || scan_i_ff == '0);
   assign rd_en   = cmd.rd_head || (cmd.scan_step && scan_valid);
   assign rd_addr = cmd.rd_head ? slot_addr(in_t, head_ff[in_t], '0)
                                : slot_addr(scan_t_ff, head_ff[scan_t_ff], scan_i_ff);
   assign wr_addr = slot_addr(in_t, head_ff[in_t], count_ff[in_t][IDX_W-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         store_ff[wr_addr] <= '{stamp: in_stamp_ff, wall: in_wall_ff,
                                length: in_len_ff, handle: in_handle_ff};
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // scan: walk every slot, keep the smallest eligible (stamp, topic, age) key
   assign cand_key  = '{stamp: rd_data_ff.stamp, topic: pend_t_ff, idx: pend_i_ff};
   assign cand_take = pend_valid_ff &&
                      (!snap_mode_ff || first_ff || cand_key > last_key_ff) &&
                      (!best_valid_ff || cand_key < best_key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_t_ff     <= '0;
         scan_i_ff     <= '0;
         pend_valid_ff <= 1'b0;
         best_valid_ff <= 1'b0;
         snap_mode_ff  <= 1'b0;
         first_ff      <= 1'b1;
         snap_cnt_ff   <= '0;
      end else begin
         pend_valid_ff <= cmd.scan_step && scan_valid;
         if (cmd.scan_start) begin
            scan_t_ff     <= '0;
            scan_i_ff     <= '0;
            best_valid_ff <= 1'b0;
         end else begin
            if (cmd.scan_step) begin
               if (scan_i_ff == IDX_W'(ENTRIES_PER_TOPIC - 1)) begin
                  scan_i_ff <= '0;
                  scan_t_ff <= scan_t_ff + 1'b1;
               end else begin
                  scan_i_ff <= scan_i_ff + 1'b1;
               end
            end
            if (cand_take) best_valid_ff <= 1'b1;
         end
         if (accept) begin
            snap_mode_ff <= 1'b0;
         end else if (cmd.snap_init) begin
            snap_mode_ff <= 1'b1;
            first_ff     <= 1'b1;
            snap_cnt_ff  <= '0;
         end else if (cmd.emit && cmd.kind == KIND_SNAP_ENTRY) begin
            first_ff    <= 1'b0;
            snap_cnt_ff <= snap_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_t_ff <= scan_t_ff;
      pend_i_ff <= scan_i_ff;
      if (cand_take && !cmd.scan_start) begin
         best_key_ff  <= cand_key;
         best_data_ff <= rd_data_ff;
      end
      if (cmd.emit && cmd.kind == KIND_SNAP_ENTRY) begin
         last_key_ff <= best_key_ff;
      end
   end

   // result word sources
   always_comb begin
      emit_entry = '0;
      emit_topic = '0;
      case (cmd.kind)
         KIND_ACCEPTED, KIND_SKIPPED: begin
            emit_entry = '{stamp: in_stamp_ff, wall: in_wall_ff,
                           length: in_len_ff, handle: in_handle_ff};
            emit_topic = in_topic_ff;
         end
         KIND_WINDOW_EVICT, KIND_CAPACITY_EVICT: begin
            emit_entry = rd_data_ff;
            emit_topic = in_topic_ff;
         end
         KIND_BUDGET_EVICT, KIND_SNAP_ENTRY: begin
            emit_entry = best_data_ff;
            emit_topic = TOPIC_W'(best_key_ff.topic);
         end
         KIND_SNAP_EMPTY: begin
            emit_entry = '0;
            emit_topic = '0;
         end
         default: begin
            emit_entry = '0;
            emit_topic = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind_ff  <= cmd.kind;
         rsp_topic_ff <= emit_topic;
         rsp_entry_ff <= emit_entry;
         rsp_total_ff <= total_in;
         rsp_count_ff <= ECOUNT_W'(ecount_in);
         rsp_last_ff  <= cmd.last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.kind           = rsp_kind_ff;
   assign rsp_chan.entry_topic    = rsp_topic_ff;
   assign rsp_chan.entry_stamp_ns = rsp_entry_ff.stamp;
   assign rsp_chan.entry_wall_ns  = rsp_entry_ff.wall;
   assign rsp_chan.entry_length   = rsp_entry_ff.length;
   assign rsp_chan.entry_handle   = rsp_entry_ff.handle;
   assign rsp_chan.total_bytes    = rsp_total_ff;
   assign rsp_chan.entry_count    = rsp_count_ff;
   assign rsp_chan.last           = rsp_last_ff;

   // budget evict closes the item when the cap is met and the new topic is empty
   assign bud_total = total_ff - TOTAL_W'(best_data_ff.length);
   assign bud_count = count_ff[in_t] - CNT_W'(best_key_ff.topic == in_t);

   always_comb begin
      status.req_valid   = req_chan.valid;
      status.is_snapshot = (in_op_ff == OP_SNAPSHOT);
      status.topic_ok    = int'(in_topic_ff) < NUM_TOPICS;
      status.keep        = (div <= 8'd1) || (arrival_ff[in_t] == '0);
      status.queue_full  = (count_ff[in_t] == CNT_W'(ENTRIES_PER_TOPIC));
      status.win_evict   = ({1'b0, rd_data_ff.stamp} + 64'(win)) < {1'b0, in_stamp_ff};
      status.over_budget = (max_bytes_ff != '0) &&
                           (CSR_DATA_W'(total_ff) > max_bytes_ff);
      status.bud_last    = (CSR_DATA_W'(bud_total) <= max_bytes_ff) && (bud_count == '0);
      status.scan_last   = (scan_t_ff == TID_W'(NUM_TOPICS - 1)) &&
                           (scan_i_ff == IDX_W'(ENTRIES_PER_TOPIC - 1));
      status.snap_empty  = (ecount_ff == '0);
      status.snap_last   = (snap_cnt_ff + 1'b1 == ecount_ff);
      status.out_free    = !rsp_valid_ff || rsp_chan.ready;
   end

endmodule
`default_nettype wire

[rtl/core/windowed_multi_queue_trace_buffer_core.sv]
// Top level of the windowed multi-queue trace buffer.
// Depends on wmqtb_pkg, the channel interfaces, wmqtb_ctrl and wmqtb_datapath.
//
// Usage:
//   req_chan carries one word per operation: a message arrival (op 0) or a
//   snapshot request (op 1). rsp_chan returns the result words for it, the
//   final one flagged by last. csr_chan writes the window, divisor and byte
//   cap registers; write them only while no operation is in flight.
//   One operation is worked at a time; ready on req_chan rises again once its
//   last result word has been loaded into the output register, so a new word
//   is taken while that result still waits for the receiver.
//   A budget evict and every snapshot entry returned each take a full pass
//   over the store (NUM_TOPICS * ENTRIES_PER_TOPIC slots) through the single
//   store read port that the oldest-head search walks; an empty buffer
//   answers a snapshot with one empty-snapshot word.
//   Reset (synchronous, active high) empties all queues, clears byte totals
//   and decimation counters and loads register defaults; the entry store is
//   not cleared and needs no pass after reset. A stalled receiver holds the
//   output word; the sequencer waits in place and nothing is dropped.
`default_nettype none
`include "windowed_multi_queue_trace_buffer_core_defines.svh"
module windowed_multi_queue_trace_buffer_core (
   input  logic        clock,
   input  logic        reset,
   wmqtb_req_if.sink   req_chan,
   wmqtb_rsp_if.source rsp_chan,
   wmqtb_csr_if.sink   csr_chan
);
   import wmqtb_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: walks each operation through read, evict, append and emit steps
   wmqtb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   // datapath: store, queue pointers, scan unit, output register
   wmqtb_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan),
      .cmd      (cmd),
      .status   (status)
   );

   // never overwrite a result word the receiver has not taken
   `WMQTB_ASSERT_IMPL(a_emit_into_free, clock, reset, cmd.emit, status.out_free)
   // one operation at a time: after accepting, stop taking words
   `WMQTB_ASSERT_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   // pop and append never hit the queues in the same cycle
   `WMQTB_ASSERT_IMPL(a_pop_xor_append, clock, reset, cmd.pop, !cmd.append)

endmodule
`default_nettype wire
